// ===== hdl/bce_pkg.sv =====
// ============================================================================
// bce_pkg
// Shared types, curve constants and microcode program of the battery charge
// estimator.
// ============================================================================
package bce_pkg;

    localparam int REG_IDX_W = 2;
    localparam int CFG_W     = 20;
    localparam int SAMPLE_W  = 12;
    localparam int MV_W      = 16;
    localparam int PCT_W     = 7;
    localparam int STEP_W    = 4;
    localparam int QUOT_W    = 16;
    localparam int ITER_W    = 4;
    localparam int CURVE_W   = 13;
    localparam int POINTS    = 11;
    localparam int SEGS      = POINTS - 1;

    localparam logic [REG_IDX_W-1:0] REG_SAMPLE_COUNT   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_DIVIDER_TOP    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_DIVIDER_BOTTOM = 2'd2;

    localparam logic [6:0]       RESET_SAMPLE_COUNT = 7'd16;
    localparam logic [CFG_W-1:0] RESET_DIVIDER      = 20'd100000;

    localparam logic [CURVE_W-1:0] CURVE_MV [POINTS] = '{
        13'd4200, 13'd4060, 13'd3980, 13'd3920, 13'd3870, 13'd3820,
        13'd3790, 13'd3770, 13'd3730, 13'd3680, 13'd3450
    };
    localparam logic [PCT_W-1:0] CURVE_PCT [POINTS] = '{
        7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50, 7'd40, 7'd30, 7'd20, 7'd10, 7'd0
    };
    localparam logic [QUOT_W-1:0] MV_SAT = 16'hFFFF;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCUM,
        OP_MUL_NUM,
        OP_MUL_DEN,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_MV_QUOT,
        OP_MV_SAT,
        OP_MV_ZERO_BOT,
        OP_PCT_SETUP,
        OP_PCT_QUOT,
        OP_EMIT
    } bce_op_t;

    typedef enum logic [3:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_REQ,
        COND_SHORT,
        COND_BOT_ZERO,
        COND_OVF,
        COND_MORE,
        COND_PCT_DONE,
        COND_OUT_BUSY
    } bce_cond_t;

    typedef struct packed {
        bce_op_t             op;
        bce_cond_t           cond;
        logic [STEP_W-1:0]   target;
    } bce_uword_t;

    typedef struct packed {
        logic no_req;
        logic short_cnt;
        logic bot_zero;
        logic ovf;
        logic more;
        logic pct_done;
        logic out_busy;
    } bce_flags_t;

    localparam logic [STEP_W-1:0] ST_WAIT  = 4'd0;
    localparam logic [STEP_W-1:0] ST_DLOOP = 4'd6;
    localparam logic [STEP_W-1:0] ST_PSET  = 4'd8;
    localparam logic [STEP_W-1:0] ST_PLOOP = 4'd10;
    localparam logic [STEP_W-1:0] ST_SAT   = 4'd12;
    localparam logic [STEP_W-1:0] ST_ZB    = 4'd13;
    localparam logic [STEP_W-1:0] ST_EMIT  = 4'd15;

    function automatic bce_uword_t bce_ucode(input logic [STEP_W-1:0] step);
        bce_uword_t w;
        w = '{op: OP_NONE, cond: COND_ALWAYS, target: ST_WAIT};
        case (step)
            4'd0:    w = '{op: OP_ACCUM,      cond: COND_NO_REQ,   target: ST_WAIT};
            4'd1:    w = '{op: OP_NONE,       cond: COND_SHORT,    target: ST_WAIT};
            4'd2:    w = '{op: OP_NONE,       cond: COND_BOT_ZERO, target: ST_ZB};
            4'd3:    w = '{op: OP_MUL_NUM,    cond: COND_NEVER,    target: ST_WAIT};
            4'd4:    w = '{op: OP_MUL_DEN,    cond: COND_NEVER,    target: ST_WAIT};
            4'd5:    w = '{op: OP_DIV_INIT,   cond: COND_OVF,      target: ST_SAT};
            4'd6:    w = '{op: OP_DIV_STEP,   cond: COND_MORE,     target: ST_DLOOP};
            4'd7:    w = '{op: OP_MV_QUOT,    cond: COND_NEVER,    target: ST_WAIT};
            4'd8:    w = '{op: OP_PCT_SETUP,  cond: COND_PCT_DONE, target: ST_EMIT};
            4'd9:    w = '{op: OP_DIV_INIT,   cond: COND_NEVER,    target: ST_WAIT};
            4'd10:   w = '{op: OP_DIV_STEP,   cond: COND_MORE,     target: ST_PLOOP};
            4'd11:   w = '{op: OP_PCT_QUOT,   cond: COND_ALWAYS,   target: ST_EMIT};
            4'd12:   w = '{op: OP_MV_SAT,     cond: COND_ALWAYS,   target: ST_PSET};
            4'd13:   w = '{op: OP_MV_ZERO_BOT, cond: COND_ALWAYS,  target: ST_PSET};
            4'd15:   w = '{op: OP_EMIT,       cond: COND_OUT_BUSY, target: ST_EMIT};
            default: w = '{op: OP_NONE,       cond: COND_ALWAYS,   target: ST_WAIT};
        endcase
        return w;
    endfunction

endpackage

// ===== hdl/bce_sequencer.sv =====
// ============================================================================
// bce_sequencer
// Step counter and microcode table; branches on datapath flags.
// ============================================================================
module bce_sequencer (
    input  logic                clk,
    input  logic                rst_n,
    input  bce_pkg::bce_flags_t flags,
    output bce_pkg::bce_uword_t uword
);
    import bce_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              taken;

    assign uword = bce_ucode(step_reg);

    always_comb
    begin
        case (uword.cond)
            COND_NEVER:    taken = 1'b0;
            COND_ALWAYS:   taken = 1'b1;
            COND_NO_REQ:   taken = flags.no_req;
            COND_SHORT:    taken = flags.short_cnt;
            COND_BOT_ZERO: taken = flags.bot_zero;
            COND_OVF:      taken = flags.ovf;
            COND_MORE:     taken = flags.more;
            COND_PCT_DONE: taken = flags.pct_done;
            COND_OUT_BUSY: taken = flags.out_busy;
            default:       taken = 1'b0;
        endcase
    end

    always_comb
    begin
        step_next = taken ? uword.target : step_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_WAIT;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

// ===== hdl/bce_datapath.sv =====
// ============================================================================
// bce_datapath
// Accumulator, shared multiplier, shift-subtract divider, curve lookup,
// configuration registers and output register.
// ============================================================================
module bce_datapath #(
    parameter int MAX_SAMPLES = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bce_pkg::bce_uword_t                 uword,
    output bce_pkg::bce_flags_t                 flags,
    input  logic                                wr_en,
    input  logic [bce_pkg::REG_IDX_W-1:0]       wr_index,
    input  logic [bce_pkg::CFG_W-1:0]           wr_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [bce_pkg::SAMPLE_W-1:0]        sample_mv,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [bce_pkg::MV_W-1:0]            battery_mv,
    output logic [bce_pkg::PCT_W-1:0]           charge_percent
);
    import bce_pkg::*;

    localparam int CW    = $clog2(MAX_SAMPLES + 1);
    localparam int SW    = $clog2(MAX_SAMPLES * 4095 + 1);
    localparam int BW    = CFG_W + 1;
    localparam int NW    = SW + BW;
    localparam int DENW  = CW + CFG_W;
    localparam int EW    = (CW > 7) ? CW : 7;
    localparam int HW    = NW - QUOT_W;
    localparam int CMPW  = (HW > DENW) ? HW : DENW;

    logic [6:0]        sample_count_reg;
    logic [CFG_W-1:0]  divider_top_reg;
    logic [CFG_W-1:0]  divider_bottom_reg;
    logic [SW-1:0]     sum_reg;
    logic [CW-1:0]     cnt_reg;
    logic [NW-1:0]     num_reg;
    logic [DENW-1:0]   den_reg;
    logic [DENW-1:0]   rem_reg;
    logic [QUOT_W-1:0] low_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic [ITER_W-1:0] iter_reg;
    logic [MV_W-1:0]   mv_reg;
    logic [PCT_W-1:0]  pct_reg;
    logic [PCT_W-1:0]  base_reg;
    logic              out_valid_reg;
    logic [MV_W-1:0]   out_mv_reg;
    logic [PCT_W-1:0]  out_pct_reg;

    logic              accept;
    logic              emit;
    logic              out_busy;
    logic [EW-1:0]     eff_count;
    logic [EW-1:0]     sc_ext;
    logic [SW-1:0]     mul_a;
    logic [BW-1:0]     mul_b;
    logic [NW-1:0]     product;
    logic [DENW:0]     trial;
    logic [DENW:0]     trial_diff;
    logic              trial_ge;
    logic [CURVE_W-1:0] seg_lo;
    logic [CURVE_W-1:0] seg_hi;
    logic [PCT_W-1:0]  seg_base;
    logic [CURVE_W-1:0] seg_offset;
    logic              above_top;
    logic              below_bottom;

    assign accept   = in_valid && (uword.op == OP_ACCUM);
    assign in_stall = (uword.op != OP_ACCUM);
    assign out_busy = out_valid_reg && out_stall;
    assign emit     = (uword.op == OP_EMIT) && !out_busy;

    assign out_valid      = out_valid_reg;
    assign battery_mv     = out_mv_reg;
    assign charge_percent = out_pct_reg;

    always_comb
    begin
        sc_ext = EW'(sample_count_reg);
        if (sc_ext == '0)
        begin
            eff_count = EW'(1);
        end
        else if (sc_ext > EW'(MAX_SAMPLES))
        begin
            eff_count = EW'(MAX_SAMPLES);
        end
        else
        begin
            eff_count = sc_ext;
        end
    end

    always_comb
    begin
        if (uword.op == OP_MUL_DEN)
        begin
            mul_a = SW'(cnt_reg);
            mul_b = BW'(divider_bottom_reg);
        end
        else
        begin
            mul_a = sum_reg;
            mul_b = BW'(divider_top_reg) + BW'(divider_bottom_reg);
        end
        product = NW'(mul_a) * NW'(mul_b);
    end

    always_comb
    begin
        trial      = {rem_reg, low_reg[QUOT_W-1]};
        trial_ge   = trial >= {1'b0, den_reg};
        trial_diff = trial - {1'b0, den_reg};
    end

    always_comb
    begin
        above_top    = mv_reg >= MV_W'(CURVE_MV[0]);
        below_bottom = mv_reg <= MV_W'(CURVE_MV[POINTS-1]);
        seg_lo       = CURVE_MV[POINTS-1];
        seg_hi       = CURVE_MV[POINTS-2];
        seg_base     = CURVE_PCT[POINTS-1];
        for (int i = SEGS - 1; i >= 0; i--)
        begin
            if (mv_reg >= MV_W'(CURVE_MV[i+1]))
            begin
                seg_lo   = CURVE_MV[i+1];
                seg_hi   = CURVE_MV[i];
                seg_base = CURVE_PCT[i+1];
            end
        end
        seg_offset = mv_reg[CURVE_W-1:0] - seg_lo;
    end

    always_comb
    begin
        flags.no_req    = !in_valid;
        flags.short_cnt = EW'(cnt_reg) < eff_count;
        flags.bot_zero  = (divider_bottom_reg == '0);
        flags.ovf       = CMPW'(num_reg[NW-1:QUOT_W]) >= CMPW'(den_reg);
        flags.more      = (iter_reg != {ITER_W{1'b1}});
        flags.pct_done  = above_top || below_bottom;
        flags.out_busy  = out_busy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg   <= RESET_SAMPLE_COUNT;
            divider_top_reg    <= RESET_DIVIDER;
            divider_bottom_reg <= RESET_DIVIDER;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_SAMPLE_COUNT:   sample_count_reg   <= wr_data[6:0];
                REG_DIVIDER_TOP:    divider_top_reg    <= wr_data;
                REG_DIVIDER_BOTTOM: divider_bottom_reg <= wr_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                sum_reg <= sum_reg + SW'(sample_mv);
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (emit)
            begin
                sum_reg <= '0;
                cnt_reg <= '0;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_mv_reg  <= mv_reg;
            out_pct_reg <= pct_reg;
        end
        case (uword.op)
            OP_MUL_NUM:
            begin
                num_reg <= product;
            end
            OP_MUL_DEN:
            begin
                den_reg <= product[DENW-1:0];
            end
            OP_DIV_INIT:
            begin
                rem_reg  <= DENW'(num_reg[NW-1:QUOT_W]);
                low_reg  <= num_reg[QUOT_W-1:0];
                quot_reg <= '0;
                iter_reg <= '0;
            end
            OP_DIV_STEP:
            begin
                rem_reg  <= trial_ge ? trial_diff[DENW-1:0] : trial[DENW-1:0];
                low_reg  <= {low_reg[QUOT_W-2:0], 1'b0};
                quot_reg <= {quot_reg[QUOT_W-2:0], trial_ge};
                iter_reg <= iter_reg + 1'b1;
            end
            OP_MV_QUOT:
            begin
                mv_reg <= quot_reg;
            end
            OP_MV_SAT:
            begin
                mv_reg <= MV_SAT;
            end
            OP_MV_ZERO_BOT:
            begin
                mv_reg <= (sum_reg == '0) ? '0 : MV_SAT;
            end
            OP_PCT_SETUP:
            begin
                pct_reg  <= above_top ? CURVE_PCT[0] : CURVE_PCT[POINTS-1];
                num_reg  <= NW'({seg_offset, 3'b000}) + NW'({seg_offset, 1'b0});
                den_reg  <= DENW'(seg_hi - seg_lo);
                base_reg <= seg_base;
            end
            OP_PCT_QUOT:
            begin
                pct_reg <= base_reg + quot_reg[PCT_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== hdl/battery_charge_estimator_core.sv =====
// ============================================================================
// battery_charge_estimator_core
// Averages millivolt samples, scales by the divider ratio and maps the
// battery voltage onto a single-cell LiPo charge curve.
//
//   channel   direction  handshake            payload
//   in        input      in_valid/in_stall    sample_mv
//   out       output     out_valid/out_stall  battery_mv, charge_percent
//   config    input      wr_en                wr_index, wr_data
//
// A sample that does not complete an estimate passes the accumulate and
// count-check steps only. A completing sample runs the microcode program:
// two 16-step passes of the shared shift-subtract divider (fewer when the
// voltage saturates or the value is off the curve).
// Reset clears the sum, the count, the step counter and the output valid.
// A stalled result holds in the output register; new samples keep coming in until the next result must be emitted.
// ============================================================================
module battery_charge_estimator_core #(
    parameter int MAX_SAMPLES = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [bce_pkg::REG_IDX_W-1:0] wr_index,
    input  logic [bce_pkg::CFG_W-1:0]     wr_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [bce_pkg::SAMPLE_W-1:0]  sample_mv,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [bce_pkg::MV_W-1:0]      battery_mv,
    output logic [bce_pkg::PCT_W-1:0]     charge_percent
);
    import bce_pkg::*;

    bce_uword_t uword;
    bce_flags_t flags;

    bce_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .uword (uword)
    );

    bce_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .uword          (uword),
        .flags          (flags),
        .wr_en          (wr_en),
        .wr_index       (wr_index),
        .wr_data        (wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .sample_mv      (sample_mv),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .battery_mv     (battery_mv),
        .charge_percent (charge_percent)
    );

endmodule
